// File: rtl/handle_registry_sorted_table_assert.svh
// Assertion macros used by the handle registry datapath.
`ifndef HANDLE_REGISTRY_SORTED_TABLE_ASSERT_SVH
`define HANDLE_REGISTRY_SORTED_TABLE_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define HRST_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define HRST_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define HRST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/hrst_pkg.sv
// Types and constants shared by the handle registry modules.
package hrst_pkg;

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned LIVE_W = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK             = 2'd0,
    ST_NOT_FOUND      = 2'd1,
    ST_FULL           = 2'd2,
    ST_KEYS_EXHAUSTED = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [KEY_W-1:0]  assigned_key;
    logic [DATA_W-1:0] found_value;
    logic [LIVE_W-1:0] live_count;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic srch_init;
    logic srch_rd;
    logic srch_step;
    logic probe_rd;
    logic hit_upd;
    logic ins_wr;
    logic set_full;
    logic set_exh;
    logic cmp_init;
    logic cmp_rd;
    logic cmp_wr;
    logic cmp_done;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       key_exh;
    logic       occ_full;
    logic       live_full;
    logic       len_zero;
    logic       lo_in_range;
    logic       hit;
    logic       cmp_more;
    logic       shrink;
    logic       out_free;
  } sts_t;

endpackage

// File: rtl/hrst_ctrl.sv
// Sequencer for insert, search, delete, compaction and result hand-off.
module hrst_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  hrst_pkg::sts_t sts_i,
  output hrst_pkg::cmd_t cmd_o
);
  import hrst_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_SRCH     = 4'd2;
  localparam logic [3:0] S_SRCH_CMP = 4'd3;
  localparam logic [3:0] S_PROBE    = 4'd4;
  localparam logic [3:0] S_DEL_CHK  = 4'd5;
  localparam logic [3:0] S_CMP_RD   = 4'd6;
  localparam logic [3:0] S_CMP_WR   = 4'd7;
  localparam logic [3:0] S_RESP     = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (sts_i.op == OP_INSERT) begin
          priority if (sts_i.key_exh) begin
            cmd_o.set_exh = 1'b1;
            state_d       = S_RESP;
          end else if (sts_i.live_full) begin
            cmd_o.set_full = 1'b1;
            state_d        = S_RESP;
          end else if (sts_i.occ_full) begin
            cmd_o.cmp_init = 1'b1;
            state_d        = S_CMP_RD;
          end else begin
            cmd_o.ins_wr = 1'b1;
            state_d      = S_RESP;
          end
        end else if (sts_i.op == OP_LOOKUP || sts_i.op == OP_DELETE) begin
          cmd_o.srch_init = 1'b1;
          state_d         = S_SRCH;
        end else begin
          state_d = S_RESP;
        end
      end
      S_SRCH: begin
        if (sts_i.len_zero) begin
          if (sts_i.lo_in_range) begin
            cmd_o.probe_rd = 1'b1;
            state_d        = S_PROBE;
          end else begin
            state_d = S_RESP;
          end
        end else begin
          cmd_o.srch_rd = 1'b1;
          state_d       = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        cmd_o.srch_step = 1'b1;
        state_d         = S_SRCH;
      end
      S_PROBE: begin
        cmd_o.hit_upd = 1'b1;
        if (sts_i.hit && sts_i.op == OP_DELETE) begin
          state_d = S_DEL_CHK;
        end else begin
          state_d = S_RESP;
        end
      end
      S_DEL_CHK: begin
        if (sts_i.shrink) begin
          cmd_o.cmp_init = 1'b1;
          state_d        = S_CMP_RD;
        end else begin
          state_d = S_RESP;
        end
      end
      S_CMP_RD: begin
        if (sts_i.cmp_more) begin
          cmd_o.cmp_rd = 1'b1;
          state_d      = S_CMP_WR;
        end else begin
          cmd_o.cmp_done = 1'b1;
          state_d        = (sts_i.op == OP_INSERT) ? S_DECODE : S_RESP;
        end
      end
      S_CMP_WR: begin
        cmd_o.cmp_wr = 1'b1;
        state_d      = S_CMP_RD;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// File: rtl/hrst_dpath.sv
// Table memory, counters, search registers and result registers.
module hrst_dpath #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hrst_pkg::in_item_t  in_item_i,
  input  hrst_pkg::cmd_t      cmd_i,
  output hrst_pkg::sts_t      sts_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output hrst_pkg::out_item_t out_item_o
);
  import hrst_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = 1 + KEY_W + VALUE_WIDTH;
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  in_item_t req_q;

  logic [EW-1:0] mem_q [CAPACITY];
  logic [EW-1:0] rd_q;

  logic [CW-1:0] lo_q, lo_d, len_q, len_d;
  logic [CW-1:0] occ_q, occ_d, live_q, live_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d, wr_idx_q, wr_idx_d;
  logic [KEY_W:0] next_key_q, next_key_d;

  status_e           res_status_q, res_status_d;
  logic [KEY_W-1:0]  res_akey_q, res_akey_d;
  logic [DATA_W-1:0] res_fval_q, res_fval_d;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic [CW-1:0] half, mid;
  logic          rd_live;
  logic [KEY_W-1:0]       rd_key;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [VALUE_WIDTH+DATA_W-1:0] in_val_ext;
  logic [VALUE_WIDTH-1:0]        in_val;
  logic [DATA_W+VALUE_WIDTH-1:0] fval_ext;
  logic [LIVE_W+CW-1:0]          live_ext;
  logic is_delete, is_lookup, hit, less, del_hit;

  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;

  assign half       = len_q >> 1;
  assign mid        = lo_q + half;
  assign rd_live    = rd_q[EW-1];
  assign rd_key     = rd_q[VALUE_WIDTH +: KEY_W];
  assign rd_val     = rd_q[VALUE_WIDTH-1:0];
  assign in_val_ext = {{VALUE_WIDTH{1'b0}}, req_q.value};
  assign in_val     = in_val_ext[VALUE_WIDTH-1:0];
  assign fval_ext   = {{DATA_W{1'b0}}, rd_val};
  assign live_ext   = {{LIVE_W{1'b0}}, live_q};
  assign is_delete  = (req_q.operation == OP_DELETE);
  assign is_lookup  = (req_q.operation == OP_LOOKUP);
  assign hit        = rd_live && (rd_key == req_q.key);
  assign less       = (rd_key < req_q.key);
  assign del_hit    = cmd_i.hit_upd && hit && is_delete;

  always_comb begin
    rd_en   = cmd_i.srch_rd || cmd_i.probe_rd || cmd_i.cmp_rd;
    rd_addr = rd_idx_q[IW-1:0];
    if (cmd_i.srch_rd) begin
      rd_addr = mid[IW-1:0];
    end else if (cmd_i.probe_rd) begin
      rd_addr = lo_q[IW-1:0];
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wr_idx_q[IW-1:0];
    wr_data = rd_q;
    priority if (cmd_i.ins_wr) begin
      wr_en   = 1'b1;
      wr_addr = occ_q[IW-1:0];
      wr_data = {1'b1, next_key_q[KEY_W-1:0], in_val};
    end else if (del_hit) begin
      wr_en   = 1'b1;
      wr_addr = lo_q[IW-1:0];
      wr_data = {1'b0, rd_q[EW-2:0]};
    end else if (cmd_i.cmp_wr && rd_live) begin
      wr_en = 1'b1;
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    lo_d         = lo_q;
    len_d        = len_q;
    occ_d        = occ_q;
    live_d       = live_q;
    rd_idx_d     = rd_idx_q;
    wr_idx_d     = wr_idx_q;
    next_key_d   = next_key_q;
    res_status_d = res_status_q;
    res_akey_d   = res_akey_q;
    res_fval_d   = res_fval_q;

    if (cmd_i.capture) begin
      res_status_d = ST_NOT_FOUND;
      res_akey_d   = '0;
      res_fval_d   = '0;
    end
    if (cmd_i.srch_init) begin
      lo_d  = '0;
      len_d = occ_q;
    end
    if (cmd_i.srch_step) begin
      if (less) begin
        lo_d  = mid + CW'(1);
        len_d = len_q - half - CW'(1);
      end else begin
        len_d = half;
      end
    end
    if (cmd_i.hit_upd && hit) begin
      res_status_d = ST_OK;
      if (is_lookup) begin
        res_fval_d = fval_ext[DATA_W-1:0];
      end
    end
    if (del_hit) begin
      live_d = live_q - CW'(1);
    end
    if (cmd_i.ins_wr) begin
      occ_d        = occ_q + CW'(1);
      live_d       = live_q + CW'(1);
      next_key_d   = next_key_q + (KEY_W+1)'(1);
      res_status_d = ST_OK;
      res_akey_d   = next_key_q[KEY_W-1:0];
    end
    if (cmd_i.set_full) begin
      res_status_d = ST_FULL;
    end
    if (cmd_i.set_exh) begin
      res_status_d = ST_KEYS_EXHAUSTED;
    end
    if (cmd_i.cmp_init) begin
      rd_idx_d = '0;
      wr_idx_d = '0;
    end
    if (cmd_i.cmp_rd) begin
      rd_idx_d = rd_idx_q + CW'(1);
    end
    if (cmd_i.cmp_wr && rd_live) begin
      wr_idx_d = wr_idx_q + CW'(1);
    end
    if (cmd_i.cmp_done) begin
      occ_d = wr_idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_item_i;
    end
    lo_q         <= lo_d;
    len_q        <= len_d;
    rd_idx_q     <= rd_idx_d;
    wr_idx_q     <= wr_idx_d;
    res_status_q <= res_status_d;
    res_akey_q   <= res_akey_d;
    res_fval_q   <= res_fval_d;
    out_q        <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      live_q      <= '0;
      next_key_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q       <= occ_d;
      live_q      <= live_d;
      next_key_q  <= next_key_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.load_out) begin
      out_d.status       = res_status_q;
      out_d.assigned_key = res_akey_q;
      out_d.found_value  = res_fval_q;
      out_d.live_count   = live_ext[LIVE_W-1:0];
      out_valid_d        = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    sts_o             = '0;
    sts_o.op          = req_q.operation;
    sts_o.key_exh     = next_key_q[KEY_W];
    sts_o.occ_full    = (occ_q == CapC);
    sts_o.live_full   = (live_q == CapC);
    sts_o.len_zero    = (len_q == '0);
    sts_o.lo_in_range = (lo_q < occ_q);
    sts_o.hit         = hit;
    sts_o.cmp_more    = (rd_idx_q < occ_q);
    sts_o.shrink      = ({live_q, 1'b0} <= {1'b0, occ_q});
    sts_o.out_free    = !out_valid_q || !out_stall_i;
  end

`include "handle_registry_sorted_table_assert.svh"

  `HRST_ASSERT_ALWAYS(a_live_within_occ, (live_q <= occ_q) && (occ_q <= CapC), "live or occupied count out of range")
  `HRST_ASSERT_IMPLIES(a_ins_has_room, cmd_i.ins_wr, !next_key_q[KEY_W] && (occ_q < CapC), "insert without room or key")
  `HRST_ASSERT_IMPLIES(a_cmp_write_behind, cmd_i.cmp_wr, wr_idx_q < rd_idx_q, "compaction write overtook read")
  `HRST_ASSERT_NEXT(a_exh_sticky, next_key_q[KEY_W], next_key_q[KEY_W], "key exhaustion flag cleared")

endmodule

// File: rtl/handle_registry_sorted_table.sv
// Top level of the sorted handle table with tombstones and compaction.
//
//   Channel  Valid        Stall        Payload
//   input    in_valid_i   in_stall_o   in_item_i  (operation, key, value)
//   output   out_valid_o  out_stall_i  out_item_o (status, assigned_key, found_value, live_count)
//
// One item is worked on at a time through a single-port table memory with a registered read.
// An insert writes the next free slot; a lookup or delete runs a binary search, each step
// a memory read and then a compare, and probes the slot found if it lies in the occupied range.
// A compaction packs the live entries down in key order; an insert then decodes once more.
// Reset empties the table at once; no clearing pass is needed.
// While a result is held, the next item is taken, but its result and the input then wait.
module handle_registry_sorted_table #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hrst_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hrst_pkg::out_item_t out_item_o
);
  import hrst_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hrst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hrst_dpath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the sorted handle table: directed and random requests.
`timescale 1ns / 1ps

module testbench;
  import hrst_pkg::*;

  localparam int unsigned CAPACITY   = 64;
  localparam int unsigned IDLE_PCT   = 11;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam logic [1:0]  OP_SPARE   = 2'd3;
  localparam logic [32:0] KEY_SPACE  = 33'h1_0000_0000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item = '0;
  logic      out_valid_o;
  logic      out_stall = 1'b0;
  out_item_t out_item_o;

  bit        steady = 1'b0;
  int unsigned bad_results = 0;
  int unsigned quiet_cycles = 0;
  out_item_t pending_results[$];
  out_item_t oldest_expected;

  // Own copy of the table, kept in step with the accepted items.
  logic [31:0] tbl_key [CAPACITY];
  logic [31:0] tbl_val [CAPACITY];
  bit          tbl_live[CAPACITY];
  logic [32:0] key_counter = '0;
  int unsigned occ_cnt = 0;
  int unsigned live_cnt = 0;

  handle_registry_sorted_table u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned first_slot_at_or_above(logic [31:0] k);
    int unsigned lo;
    int unsigned len;
    int unsigned half;
    lo = 0;
    len = occ_cnt;
    while (len > 0) begin
      half = len / 2;
      if (tbl_key[lo + half] < k) begin
        lo = lo + half + 1;
        len = len - half - 1;
      end else begin
        len = half;
      end
    end
    return lo;
  endfunction

  // Live entries slide down in key order; dead slots above them are cleared.
  function automatic void squeeze_table();
    int unsigned w;
    int unsigned r;
    w = 0;
    for (r = 0; r < occ_cnt; r++) begin
      if (tbl_live[r]) begin
        tbl_key[w] = tbl_key[r];
        tbl_val[w] = tbl_val[r];
        tbl_live[w] = 1'b1;
        w++;
      end
    end
    for (r = w; r < CAPACITY; r++) begin
      tbl_live[r] = 1'b0;
    end
    occ_cnt = w;
  endfunction

  function automatic out_item_t registry_apply(in_item_t req);
    out_item_t   res;
    int unsigned s;
    res = '0;
    res.status = ST_NOT_FOUND;
    case (req.operation)
      OP_INSERT: begin
        if (key_counter >= KEY_SPACE) begin
          res.status = ST_KEYS_EXHAUSTED;
        end else begin
          if (occ_cnt >= CAPACITY) squeeze_table();
          if (occ_cnt >= CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            tbl_key[occ_cnt] = key_counter[31:0];
            tbl_val[occ_cnt] = req.value;
            tbl_live[occ_cnt] = 1'b1;
            res.assigned_key = key_counter[31:0];
            key_counter++;
            occ_cnt++;
            live_cnt++;
            res.status = ST_OK;
          end
        end
      end
      OP_LOOKUP, OP_DELETE: begin
        s = first_slot_at_or_above(req.key);
        if (s < occ_cnt && tbl_live[s] && tbl_key[s] == req.key) begin
          res.status = ST_OK;
          if (req.operation == OP_LOOKUP) begin
            res.found_value = tbl_val[s];
          end else begin
            tbl_live[s] = 1'b0;
            live_cnt--;
            if (live_cnt * 2 <= occ_cnt) squeeze_table();
          end
        end
      end
      default: ;
    endcase
    res.live_count = live_cnt[LIVE_W-1:0];
    return res;
  endfunction

  function automatic logic [31:0] pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55 && occ_cnt > 0) return tbl_key[$urandom_range(occ_cnt - 1)];
    if (r < 80) return key_counter[31:0] + 32'd2 - 32'($urandom_range(5));
    return $urandom();
  endfunction

  task automatic send_request(input logic [1:0] op, input logic [31:0] k,
                              input logic [31:0] v);
    in_item_t req;
    req.operation = op;
    req.key = k;
    req.value = v;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(registry_apply(req));
  endtask

  task automatic test_empty_table();
    send_request(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_DELETE, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_SPARE, 32'h0000_0000, 32'h0000_0000);
  endtask

  task automatic test_insert_lookup();
    logic [31:0] base;
    base = key_counter[31:0];
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'h1234_5678, 32'h5555_5555);
    send_request(OP_INSERT, 32'h8765_4321, 32'hAAAA_AAAA);
    send_request(OP_LOOKUP, base, 32'h0000_0000);
    send_request(OP_LOOKUP, base + 32'd1, 32'h0000_0000);
    send_request(OP_LOOKUP, base + 32'd3, 32'h0000_0000);
    send_request(OP_LOOKUP, base + 32'd4, 32'h0000_0000);
    send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_SPARE, base, 32'h0000_0000);
  endtask

  // Two deletes out of four occupied slots bring the table to the compaction point.
  task automatic test_delete();
    logic [31:0] base;
    base = key_counter[31:0] - 32'd4;
    send_request(OP_DELETE, base + 32'd1, 32'h0000_0000);
    send_request(OP_DELETE, base + 32'd1, 32'h0000_0000);
    send_request(OP_LOOKUP, base + 32'd1, 32'h0000_0000);
    send_request(OP_DELETE, base + 32'd2, 32'h0000_0000);
    send_request(OP_LOOKUP, base, 32'h0000_0000);
    send_request(OP_LOOKUP, base + 32'd3, 32'h0000_0000);
    send_request(OP_DELETE, base + 32'd9, 32'h0000_0000);
  endtask

  task automatic test_table_full();
    logic [31:0] held_keys[$];
    int unsigned n;
    while (live_cnt < CAPACITY) send_request(OP_INSERT, $urandom(), $urandom());
    send_request(OP_INSERT, $urandom(), $urandom());
    send_request(OP_DELETE, tbl_key[CAPACITY / 2], $urandom());
    send_request(OP_INSERT, $urandom(), $urandom());
    send_request(OP_INSERT, $urandom(), $urandom());
    send_request(OP_LOOKUP, tbl_key[0], $urandom());
    send_request(OP_LOOKUP, tbl_key[CAPACITY - 1], $urandom());
    for (n = 0; n < CAPACITY; n++) held_keys.push_back(tbl_key[n]);
    for (n = 0; n < 40; n++) send_request(OP_DELETE, held_keys[n], $urandom());
  endtask

  task automatic test_random_traffic();
    int unsigned burst;
    int unsigned n;
    int unsigned r;
    int unsigned insert_pct;
    for (burst = 0; burst < 30; burst++) begin
      steady = (burst >= 12 && burst < 16);
      insert_pct = 20 + 25 * $urandom_range(2);
      for (n = 0; n < 50; n++) begin
        r = $urandom_range(99);
        if (r < 3) begin
          send_request(OP_SPARE, $urandom(), $urandom());
        end else if (r < 3 + insert_pct) begin
          send_request(OP_INSERT, $urandom(), $urandom());
        end else if (r % 2 == 0) begin
          send_request(OP_LOOKUP, pick_key(), $urandom());
        end else begin
          send_request(OP_DELETE, pick_key(), $urandom());
        end
      end
    end
    steady = 1'b0;
  endtask

  always @(posedge clk_i) begin
    out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (pending_results.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected result: status %0d key %h value %h live %0d",
                   out_item_o.status, out_item_o.assigned_key,
                   out_item_o.found_value, out_item_o.live_count);
      end else begin
        oldest_expected = pending_results.pop_front();
        if (out_item_o.status !== oldest_expected.status ||
            out_item_o.assigned_key !== oldest_expected.assigned_key ||
            out_item_o.found_value !== oldest_expected.found_value ||
            out_item_o.live_count !== oldest_expected.live_count) begin
          bad_results++;
          if (bad_results <= 10)
            $display("mismatch: expected status %0d key %h value %h live %0d, %s",
                     oldest_expected.status, oldest_expected.assigned_key,
                     oldest_expected.found_value, oldest_expected.live_count,
                     $sformatf("got status %0d key %h value %h live %0d",
                               out_item_o.status, out_item_o.assigned_key,
                               out_item_o.found_value, out_item_o.live_count));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
        (!in_valid && pending_results.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("** handle_registry_sorted_table: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_insert_lookup();
    test_delete();
    test_table_full();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (bad_results == 0) begin
      $display("** handle_registry_sorted_table: PASSED **");
    end else begin
      $display("** handle_registry_sorted_table: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/hrst_pkg.sv
rtl/hrst_ctrl.sv
rtl/hrst_dpath.sv
rtl/handle_registry_sorted_table.sv
bench/testbench.sv
